// File: rtl/core/dbhp_pkg.sv
`timescale 1ns / 1ps
package dbhp_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] KIND_ERRNAME = 3'd0;
    localparam logic [2:0] KIND_SIG     = 3'd1;
    localparam logic [2:0] KIND_BODY    = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_REJECT  = 3'd4;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_ENDIAN  = 3'd1;
    localparam logic [2:0] CAUSE_OVERRUN = 3'd2;
    localparam logic [2:0] CAUSE_VARIANT = 3'd3;
    localparam logic [2:0] CAUSE_ENDED   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic        run_last;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic        big_endian;
        logic [31:0] serial_number;
        logic [31:0] resp_serial;
        logic        resp_serial_seen;
        logic [31:0] fd_count;
        logic        fd_count_seen;
        logic [2:0]  error_cause;
    } out_t;

    // Results caused by one input transaction: one or two.
    typedef struct packed {
        logic       two;
        out_t       res0;
        out_t       res1;
    } pair_t;

endpackage

// File: rtl/core/dbhp_front.sv
`timescale 1ns / 1ps
module dbhp_front
    import dbhp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_fire,
    input  in_t   in_data,
    output logic  push,
    output pair_t push_data
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HDR     = 4'd1;
    localparam logic [3:0] PH_ALIGN8  = 4'd2;
    localparam logic [3:0] PH_CODE    = 4'd3;
    localparam logic [3:0] PH_SIGLEN  = 4'd4;
    localparam logic [3:0] PH_SIG     = 4'd5;
    localparam logic [3:0] PH_PAD4    = 4'd6;
    localparam logic [3:0] PH_WORD    = 4'd7;
    localparam logic [3:0] PH_GLEN    = 4'd8;
    localparam logic [3:0] PH_STR     = 4'd9;
    localparam logic [3:0] PH_NUL     = 4'd10;
    localparam logic [3:0] PH_BODYPAD = 4'd11;
    localparam logic [3:0] PH_BODY    = 4'd12;

    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_O = 8'h6F;
    localparam logic [7:0] CH_G = 8'h67;
    localparam logic [7:0] FC_ERRNAME = 8'd4;
    localparam logic [7:0] FC_REPLY   = 8'd5;
    localparam logic [7:0] FC_SIG     = 8'd8;
    localparam logic [7:0] FC_FDS     = 8'd9;

    typedef struct packed {
        logic [3:0]  phase;
        logic [32:0] rem;
        logic        fin;
        logic        bad;
    } step_t;

    logic [3:0]  phase_reg, phase_next;
    logic [33:0] pos_reg, pos_next;
    logic        big_reg, big_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] blen_reg, blen_next;
    logic [32:0] fend_reg, fend_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] serial_reg, serial_next;
    logic [31:0] rser_reg, rser_next;
    logic        rser_seen_reg, rser_seen_next;
    logic [31:0] fds_reg, fds_next;
    logic        fds_seen_reg, fds_seen_next;
    logic [7:0]  fcode_reg, fcode_next;
    logic [7:0]  vcode_reg, vcode_next;
    logic [32:0] rem_reg, rem_next;

    // Next field, or padding and body (or the end of the message) once the field array is used up.
    function automatic step_t field_top(logic [33:0] p, logic [32:0] fend,
                                        logic [31:0] blen);
        step_t       s;
        logic [34:0] a8;
        logic [2:0]  pad;
        a8  = ({1'b0, p} + 35'd7) & ~35'd7;
        pad = a8[2:0] - p[2:0];
        s   = '0;
        if (a8 >= {2'b00, fend}) begin
            if (pad != 3'd0) begin
                s.rem   = {30'd0, pad};
                s.phase = PH_BODYPAD;
            end else if (blen != 32'd0) begin
                s.rem   = {1'b0, blen};
                s.phase = PH_BODY;
            end else begin
                s.fin   = 1'b1;
                s.phase = PH_IDLE;
            end
        end else if (pad != 3'd0) begin
            s.rem   = {30'd0, pad};
            s.phase = PH_ALIGN8;
        end else begin
            s.phase = PH_CODE;
        end
        return s;
    endfunction

    function automatic step_t value_start(logic [33:0] p, logic [32:0] fend,
                                          logic [7:0] vcode);
        step_t       s;
        logic [35:0] a4;
        s  = '0;
        a4 = ({2'b00, p} + 36'd3) & ~36'd3;
        if (vcode == CH_G) begin
            if ({1'b0, p} >= {2'b00, fend}) s.bad = 1'b1;
            else s.phase = PH_GLEN;
        end else if (a4 + 36'd4 > {3'b000, fend}) begin
            s.bad = 1'b1;
        end else if (a4[1:0] != p[1:0]) begin
            s.rem   = {31'd0, a4[1:0] - p[1:0]};
            s.phase = PH_PAD4;
        end else begin
            s.phase = PH_WORD;
        end
        return s;
    endfunction

    logic [7:0]  b;
    logic [33:0] np;
    logic [31:0] wa;
    step_t       st;
    out_t        done_r;
    logic [35:0] lim;

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        big_next       = big_reg;
        word_next      = word_reg;
        blen_next      = blen_reg;
        fend_next      = fend_reg;
        type_next      = type_reg;
        flags_next     = flags_reg;
        serial_next    = serial_reg;
        rser_next      = rser_reg;
        rser_seen_next = rser_seen_reg;
        fds_next       = fds_reg;
        fds_seen_next  = fds_seen_reg;
        fcode_next     = fcode_reg;
        vcode_next     = vcode_reg;
        rem_next       = rem_reg;
        push           = 1'b0;
        push_data      = '0;
        b              = in_data.in_byte;
        np             = pos_reg + 34'd1;
        wa             = big_reg ? {word_reg[23:0], b} : {b, word_reg[31:8]};
        st             = '0;
        lim            = '0;

        if (in_fire) begin
            if (in_data.stream_end) begin
                if (phase_reg != PH_IDLE) begin
                    push = 1'b1;
                    push_data.res0.out_kind    = KIND_REJECT;
                    push_data.res0.error_cause = CAUSE_ENDED;
                    phase_next = PH_IDLE;
                end
            end else begin
                pos_next = np;
                case (phase_reg)
                    PH_IDLE: begin
                        if (b == CH_L || b == CH_B) begin
                            big_next       = (b == CH_B);
                            word_next      = '0;
                            blen_next      = '0;
                            fend_next      = '0;
                            type_next      = '0;
                            flags_next     = '0;
                            serial_next    = '0;
                            rser_next      = '0;
                            rser_seen_next = 1'b0;
                            fds_next       = '0;
                            fds_seen_next  = 1'b0;
                            fcode_next     = '0;
                            vcode_next     = '0;
                            rem_next       = '0;
                            pos_next       = 34'd1;
                            phase_next     = PH_HDR;
                        end else begin
                            pos_next = '0;
                            push = 1'b1;
                            push_data.res0.out_kind    = KIND_REJECT;
                            push_data.res0.error_cause = CAUSE_ENDIAN;
                        end
                    end
                    PH_HDR: begin
                        if (pos_reg == 34'd1) type_next = b;
                        else if (pos_reg == 34'd2) flags_next = b;
                        else if (pos_reg >= 34'd4) word_next = wa;
                        if (pos_reg == 34'd7) blen_next = wa;
                        else if (pos_reg == 34'd11) serial_next = wa;
                        else if (pos_reg >= 34'd15) begin
                            fend_next  = 33'd16 + {1'b0, wa};
                            st         = field_top(np, fend_next, blen_reg);
                            phase_next = st.phase;
                            rem_next   = st.rem;
                        end
                    end
                    PH_ALIGN8, PH_PAD4: begin
                        rem_next = rem_reg - 33'd1;
                        if (rem_next == '0) begin
                            phase_next = (phase_reg == PH_ALIGN8) ? PH_CODE : PH_WORD;
                        end
                    end
                    PH_CODE: begin
                        fcode_next = b;
                        if ({1'b0, np} >= {2'b00, fend_reg}) st.bad = 1'b1;
                        else phase_next = PH_SIGLEN;
                    end
                    PH_SIGLEN, PH_GLEN: begin
                        lim = {2'b00, np} + {28'd0, b} + 36'd1;
                        if (lim > {3'b000, fend_reg}) st.bad = 1'b1;
                        else if (phase_reg == PH_SIGLEN) begin
                            if (b == 8'd0) begin
                                push = 1'b1;
                                push_data.res0.out_kind    = KIND_REJECT;
                                push_data.res0.error_cause = CAUSE_VARIANT;
                                phase_next = PH_IDLE;
                            end else begin
                                vcode_next = '0;
                                rem_next   = {25'd0, b} + 33'd1;
                                phase_next = PH_SIG;
                            end
                        end else if (b == 8'd0) begin
                            phase_next = PH_NUL;
                        end else begin
                            rem_next   = {25'd0, b};
                            phase_next = PH_STR;
                        end
                    end
                    PH_SIG: begin
                        if (vcode_reg == 8'd0 && !(b == CH_U || b == CH_S ||
                                                   b == CH_O || b == CH_G)) begin
                            push = 1'b1;
                            push_data.res0.out_kind    = KIND_REJECT;
                            push_data.res0.error_cause = CAUSE_VARIANT;
                            phase_next = PH_IDLE;
                        end else begin
                            if (vcode_reg == 8'd0) vcode_next = b;
                            rem_next = rem_reg - 33'd1;
                            if (rem_next == '0) begin
                                st = value_start(np, fend_reg, vcode_next);
                                if (!st.bad) begin
                                    phase_next = st.phase;
                                    rem_next   = st.rem;
                                end
                            end
                        end
                    end
                    PH_WORD: begin
                        word_next = wa;
                        if (pos_reg[1:0] == 2'b11) begin
                            lim = {2'b00, np} + {4'd0, wa} + 36'd1;
                            if (vcode_reg == CH_U) begin
                                if (fcode_reg == FC_REPLY) begin
                                    rser_next      = wa;
                                    rser_seen_next = 1'b1;
                                end else if (fcode_reg == FC_FDS) begin
                                    fds_next      = wa;
                                    fds_seen_next = 1'b1;
                                end
                                st         = field_top(np, fend_reg, blen_reg);
                                phase_next = st.phase;
                                rem_next   = st.rem;
                            end else if (lim > {3'b000, fend_reg}) begin
                                st.bad = 1'b1;
                            end else if (wa == 32'd0) begin
                                phase_next = PH_NUL;
                            end else begin
                                rem_next   = {1'b0, wa};
                                phase_next = PH_STR;
                            end
                        end
                    end
                    PH_STR: begin
                        rem_next = rem_reg - 33'd1;
                        push_data.res0.out_byte = b;
                        push_data.res0.run_last = (rem_next == '0);
                        if (vcode_reg == CH_G) begin
                            push_data.res0.out_kind = KIND_SIG;
                            push = (fcode_reg == FC_SIG);
                        end else begin
                            push_data.res0.out_kind = KIND_ERRNAME;
                            push = (fcode_reg == FC_ERRNAME);
                        end
                        if (rem_next == '0) phase_next = PH_NUL;
                    end
                    PH_NUL: begin
                        st         = field_top(np, fend_reg, blen_reg);
                        phase_next = st.phase;
                        rem_next   = st.rem;
                    end
                    PH_BODYPAD: begin
                        rem_next = rem_reg - 33'd1;
                        if (rem_next == '0) begin
                            if (blen_reg != 32'd0) begin
                                rem_next   = {1'b0, blen_reg};
                                phase_next = PH_BODY;
                            end else begin
                                st.fin     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_BODY: begin
                        rem_next = rem_reg - 33'd1;
                        push = 1'b1;
                        push_data.res0.out_kind = KIND_BODY;
                        push_data.res0.out_byte = b;
                        push_data.res0.run_last = (rem_next == '0);
                        if (rem_next == '0) begin
                            push_data.two = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (st.bad) begin
                    push = 1'b1;
                    push_data.res0.out_kind    = KIND_REJECT;
                    push_data.res0.error_cause = CAUSE_OVERRUN;
                    phase_next = PH_IDLE;
                end
            end
        end

        done_r                  = '0;
        done_r.out_kind         = KIND_DONE;
        done_r.msg_type         = type_next;
        done_r.msg_flags        = flags_next;
        done_r.big_endian       = big_next;
        done_r.serial_number    = serial_next;
        done_r.resp_serial      = rser_next;
        done_r.resp_serial_seen = rser_seen_next;
        done_r.fd_count         = fds_next;
        done_r.fd_count_seen    = fds_seen_next;
        // Only a finishing body byte brings a second result.
        if (push_data.two) push_data.res1 = done_r;
        if (st.fin) begin
            push           = 1'b1;
            push_data.res0 = done_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            big_reg       <= 1'b0;
            word_reg      <= '0;
            blen_reg      <= '0;
            fend_reg      <= '0;
            type_reg      <= '0;
            flags_reg     <= '0;
            serial_reg    <= '0;
            rser_reg      <= '0;
            rser_seen_reg <= 1'b0;
            fds_reg       <= '0;
            fds_seen_reg  <= 1'b0;
            fcode_reg     <= '0;
            vcode_reg     <= '0;
            rem_reg       <= '0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            big_reg       <= big_next;
            word_reg      <= word_next;
            blen_reg      <= blen_next;
            fend_reg      <= fend_next;
            type_reg      <= type_next;
            flags_reg     <= flags_next;
            serial_reg    <= serial_next;
            rser_reg      <= rser_next;
            rser_seen_reg <= rser_seen_next;
            fds_reg       <= fds_next;
            fds_seen_reg  <= fds_seen_next;
            fcode_reg     <= fcode_next;
            vcode_reg     <= vcode_next;
            rem_reg       <= rem_next;
        end
    end

    a_idle_end_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_data.stream_end && phase_reg == PH_IDLE) |-> !push)
        else $error("stream end while idle produced a result");
    a_two_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_data.two) |-> (push_data.res0.out_kind == KIND_BODY &&
                                     push_data.res1.out_kind == KIND_DONE))
        else $error("second result is not a done after a body byte");
    a_reject_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_data.res0.out_kind == KIND_REJECT) |=> phase_reg == PH_IDLE)
        else $error("parser not idle after a rejection");

endmodule

// File: rtl/core/dbhp_fifo.sv
`timescale 1ns / 1ps
module dbhp_fifo
    import dbhp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  pair_t push_data,
    output logic  full,
    output logic  empty,
    input  logic  pop,
    output pair_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pair_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (do_pop) rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        if (do_push && !do_pop) cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (empty || full) |-> (wr_reg == rd_reg))
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/core/dbhp_back.sv
`timescale 1ns / 1ps
module dbhp_back
    import dbhp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  empty,
    input  pair_t head,
    output logic  pop,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    logic sel_reg, sel_next;

    assign m_valid = !empty;
    assign m_data  = sel_reg ? head.res1 : head.res0;
    // An entry leaves the queue once its last result is taken.
    assign pop     = m_valid && m_ready && (sel_reg || !head.two);

    always_comb begin
        sel_next = sel_reg;
        if (m_valid && m_ready) sel_next = !pop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sel_reg <= 1'b0;
        else sel_reg <= sel_next;
    end

    a_sel_two: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (m_valid && head.two))
        else $error("second slot selected on a single-result entry");
    a_sel_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !sel_reg && head.two) |=> sel_reg)
        else $error("second result of a pair skipped");
    a_pop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> !sel_reg)
        else $error("slot select not cleared after pop");

endmodule

// File: rtl/core/dbus_header_stream_parser.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake         | Payload
// s_       | in        | s_valid / s_ready | in_t  (in_byte, stream_end)
// m_       | out       | m_valid / m_ready | out_t (one result)
//
// One byte per cycle while s_ready is high: the parser state updates on every
// accepted transaction. Results pass through a short queue; s_ready drops only
// when the queue is full; a two-result entry stays until both are taken.
// Reset (aresetn low, synchronous) idles the parser and empties the queue.
// A stalled m_ready holds results in the queue while parsing continues.
module dbus_header_stream_parser
    import dbhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic  push, full, empty, pop, in_fire;
    pair_t push_data, head;

    assign s_ready = !full;
    assign in_fire = s_valid && s_ready;

    dbhp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_data   (s_data),
        .push      (push),
        .push_data (push_data)
    );

    dbhp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    dbhp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
